// ===== design/fat_cluster_run_walker_core_macros.svh =====
`ifndef FAT_CLUSTER_RUN_WALKER_CORE_MACROS_SVH
`define FAT_CLUSTER_RUN_WALKER_CORE_MACROS_SVH

// Concurrent check on clk_i that is switched off while rst_ni is low.
`define FCRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on clk_i that also holds while reset is applied.
`define FCRW_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/fcrw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrw_pkg
// Shared constants, codes and types of the FAT cluster run walker.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrw_pkg;

  localparam int unsigned TableWords = 16384;
  localparam int unsigned TableAw    = $clog2(TableWords);
  localparam int unsigned ByteAw     = TableAw + 2;
  localparam int unsigned MaxSectors = 16;
  localparam int unsigned SecW       = $clog2(MaxSectors + 1);

  localparam logic [31:0] ChainEnd   = 32'hFFFF_FFFF;
  localparam logic [31:0] Fat12Limit = 32'h0000_0FF8;
  localparam logic [31:0] Fat16Limit = 32'h0000_FFF8;
  localparam logic [31:0] Fat32Limit = 32'h0FFF_FFF8;

  // Request opcodes.
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpNext  = 2'd2;

  // File system formats; any other code is handled as FAT32.
  localparam logic [1:0] FsFat12 = 2'd0;
  localparam logic [1:0] FsFat16 = 2'd1;

  // Configuration register indexes.
  localparam logic [2:0] CfgFsType      = 3'd0;
  localparam logic [2:0] CfgSecPerClus  = 3'd1;
  localparam logic [2:0] CfgFatCopies   = 3'd2;
  localparam logic [2:0] CfgSecPerFat   = 3'd3;
  localparam logic [2:0] CfgReserved    = 3'd4;
  localparam logic [2:0] CfgRootEntries = 3'd5;

  typedef struct packed {
    logic [1:0]  fs_type;
    logic [4:0]  sectors_per_cluster;
    logic [2:0]  fat_copies;
    logic [23:0] sectors_per_fat;
    logic [15:0] reserved_sectors;
    logic [15:0] root_entry_count;
  } cfg_t;

  typedef struct packed {
    logic mem_write;
    logic load_cur;
    logic emit_end;
    logic begin_run;
    logic rd_second;
    logic capture_lo;
    logic capture_hi;
    logic extract;
    logic merge;
    logic finish;
    logic multiply;
    logic emit_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cur_is_end;
    logic straddle;
    logic can_merge;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/fcrw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fcrw_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrw_cfg_regs
  import fcrw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFsType:      cfg_d.fs_type             = cfg_data_i[1:0];
        CfgSecPerClus:  cfg_d.sectors_per_cluster = cfg_data_i[4:0];
        CfgFatCopies:   cfg_d.fat_copies          = cfg_data_i[2:0];
        CfgSecPerFat:   cfg_d.sectors_per_fat     = cfg_data_i;
        CfgReserved:    cfg_d.reserved_sectors    = cfg_data_i[15:0];
        CfgRootEntries: cfg_d.root_entry_count    = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fs_type             <= FsFat12;
      cfg_q.sectors_per_cluster <= 5'd1;
      cfg_q.fat_copies          <= 3'd2;
      cfg_q.sectors_per_fat     <= 24'd9;
      cfg_q.reserved_sectors    <= 16'd1;
      cfg_q.root_entry_count    <= 16'd224;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/fcrw_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcrw_ctrl
// Controller: sequences FAT lookups, run merging and the LBA computation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_cluster_run_walker_core_macros.svh"

module fcrw_ctrl
  import fcrw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] opcode_i,
  output logic            busy_o,
  output ctrl_cmd_t       cmd_o,
  input  dp_status_t      sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_EXT  = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_SUM  = 3'd7;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (opcode_i)
            OpWrite: cmd_o.mem_write = 1'b1;
            OpStart: cmd_o.load_cur  = 1'b1;
            OpNext: begin
              if (sts_i.cur_is_end) begin
                cmd_o.emit_end = 1'b1;
              end else begin
                cmd_o.begin_run = 1'b1;
                state_d         = S_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: begin
        cmd_o.capture_lo = 1'b1;
        // A FAT12 entry in the last byte of a word needs the following word too.
        if (sts_i.straddle) begin
          cmd_o.rd_second = 1'b1;
          state_d         = S_RD2;
        end else begin
          state_d = S_EXT;
        end
      end
      S_RD2: begin
        cmd_o.rd_second  = 1'b1;
        cmd_o.capture_hi = 1'b1;
        state_d          = S_EXT;
      end
      S_EXT: begin
        cmd_o.extract = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.can_merge) begin
          cmd_o.merge = 1'b1;
          state_d     = S_RD0;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.multiply = 1'b1;
        state_d        = S_SUM;
      end
      S_SUM: begin
        cmd_o.emit_run = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FCRW_ASSERT(a_emit_returns_idle, (cmd_o.emit_run || cmd_o.emit_end) |=> (state_q == S_IDLE), "controller did not return to idle after a result")
  `FCRW_ASSERT(a_second_read_straddle, (state_q == S_RD2) |-> $past(sts_i.straddle), "second table read without a straddling entry")

endmodule

`default_nettype wire

// ===== design/fcrw_datapath.sv =====
// ----------------------------------------------------------------------------
// fcrw_datapath
// FAT table memory, entry extraction, run merging and LBA arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_cluster_run_walker_core_macros.svh"

module fcrw_datapath
  import fcrw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cfg_t             cfg_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       sts_o,
  input  wire logic [13:0] table_word_index_i,
  input  wire logic [31:0] table_word_data_i,
  input  wire logic [31:0] first_cluster_i,
  output logic             done_o,
  output logic [31:0]      run_lba_o,
  output logic [4:0]       run_sectors_o,
  output logic             last_run_o,
  output logic             status_o
);

  localparam logic [SecW:0] MaxSecExt = (SecW + 1)'(MaxSectors);

  logic [31:0] fat_mem_q [TableWords];
  logic [31:0] rd_q;

  logic [31:0]       cur_q, start_q, look_q, nxt_q;
  logic [31:0]       lo_q, hi_q, p1_q, p2_q;
  logic [SecW-1:0]   sec_q;
  logic [31:0]       run_lba_q;
  logic [4:0]        run_sectors_q;
  logic              last_q, status_q, done_q;

  logic [SecW-1:0]   spc;
  logic [ByteAw-1:0] byte_addr;
  logic [TableAw-1:0] word_idx, rd_idx, wr_idx;
  logic [1:0]        byte_off;
  logic [15:0]       half;
  logic [31:0]       entry, limit, nxt_d, root_skip;

  // Cluster size is clamped to the range one to MaxSectors.
  always_comb begin
    if (cfg_i.sectors_per_cluster == 5'd0) begin
      spc = SecW'(1);
    end else if (cfg_i.sectors_per_cluster > MaxSectors) begin
      spc = SecW'(MaxSectors);
    end else begin
      spc = SecW'(cfg_i.sectors_per_cluster);
    end
  end

  // Byte address of the entry, wrapping at the table size.
  always_comb begin
    unique case (cfg_i.fs_type)
      FsFat12: byte_addr = look_q[ByteAw-1:0] + look_q[ByteAw:1];
      FsFat16: byte_addr = {look_q[ByteAw-2:0], 1'b0};
      default: byte_addr = {look_q[ByteAw-3:0], 2'b00};
    endcase
  end

  assign word_idx = byte_addr[ByteAw-1:2];
  assign byte_off = byte_addr[1:0];
  assign rd_idx   = cmd_i.rd_second ? (word_idx + TableAw'(1)) : word_idx;
  assign wr_idx   = TableAw'(table_word_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      fat_mem_q[wr_idx] <= table_word_data_i;
    end
    rd_q <= fat_mem_q[rd_idx];
  end

  always_comb begin
    unique case (byte_off)
      2'd0:    half = lo_q[15:0];
      2'd1:    half = lo_q[23:8];
      2'd2:    half = lo_q[31:16];
      default: half = {hi_q[7:0], lo_q[31:24]};
    endcase
  end

  always_comb begin
    unique case (cfg_i.fs_type)
      FsFat12: begin
        entry = {20'd0, look_q[0] ? half[15:4] : half[11:0]};
        limit = Fat12Limit;
      end
      FsFat16: begin
        entry = {16'd0, half};
        limit = Fat16Limit;
      end
      default: begin
        entry = lo_q;
        limit = Fat32Limit;
      end
    endcase
    nxt_d = (entry >= limit) ? ChainEnd : entry;
  end

  assign root_skip = ((cfg_i.fs_type == FsFat12) || (cfg_i.fs_type == FsFat16))
                   ? 32'(cfg_i.root_entry_count[15:4]) : 32'd0;

  assign sts_o.cur_is_end = (cur_q == ChainEnd);
  assign sts_o.straddle   = (cfg_i.fs_type == FsFat12) && (byte_off == 2'd3);
  // Merging only continues with the cluster right after the last one looked up.
  assign sts_o.can_merge  = (nxt_q != ChainEnd) && (nxt_q == look_q + 32'd1)
                         && (({1'b0, sec_q} + {1'b0, spc}) <= MaxSecExt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= ChainEnd;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.load_cur) begin
        cur_q <= first_cluster_i;
      end else if (cmd_i.finish) begin
        cur_q <= nxt_q;
      end
      done_q <= cmd_i.emit_run | cmd_i.emit_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_run) begin
      start_q <= cur_q;
      look_q  <= cur_q;
      sec_q   <= spc;
    end else if (cmd_i.merge) begin
      look_q <= nxt_q;
      sec_q  <= sec_q + spc;
    end
    if (cmd_i.capture_lo) begin
      lo_q <= rd_q;
    end
    if (cmd_i.capture_hi) begin
      hi_q <= rd_q;
    end
    if (cmd_i.extract) begin
      nxt_q <= nxt_d;
    end
    if (cmd_i.multiply) begin
      p1_q <= 32'(cfg_i.sectors_per_fat) * 32'(cfg_i.fat_copies);
      p2_q <= (start_q - 32'd2) * 32'(spc);
    end
    if (cmd_i.emit_run) begin
      run_lba_q     <= p1_q + p2_q + 32'(cfg_i.reserved_sectors) + root_skip;
      run_sectors_q <= 5'(sec_q);
      last_q        <= (cur_q == ChainEnd);
      status_q      <= 1'b0;
    end else if (cmd_i.emit_end) begin
      run_lba_q     <= 32'd0;
      run_sectors_q <= 5'd0;
      last_q        <= 1'b0;
      status_q      <= 1'b1;
    end
  end

  assign done_o        = done_q;
  assign run_lba_o     = run_lba_q;
  assign run_sectors_o = run_sectors_q;
  assign last_run_o    = last_q;
  assign status_o      = status_q;

  `FCRW_ASSERT(a_run_size, cmd_i.emit_run |-> ((sec_q != '0) && (sec_q <= SecW'(MaxSectors))), "run sector count out of range")
  `FCRW_ASSERT_NR(a_end_payload, (done_q && status_q) |-> ((run_lba_q == '0) && (run_sectors_q == '0) && !last_q), "ended chain reported with a run payload")

endmodule

`default_nettype wire

// ===== design/fat_cluster_run_walker_core.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_run_walker_core
// Walks FAT12/FAT16/FAT32 cluster chains held in an on-chip FAT table copy.
// ----------------------------------------------------------------------------
// Requests enter on start_i while busy_o is low. opcode_i selects a table word
// write (table_word_index_i, table_word_data_i), a chain start
// (first_cluster_i) or a run request. Table writes and chain starts give no
// result. A run request gives exactly one result, shown on
// run_lba_o, run_sectors_o, last_run_o and status_o while done_o is high for
// one cycle; the receiver must take it then, it cannot stall the block.
// A run request on an ended chain returns status 1 in the next cycle.
// Otherwise the run walks n FAT entries (1 to MaxSectors), each a registered
// read of the single table memory through states RD0, RD1, EXT and EVAL, with
// RD2 added for a FAT12 entry that crosses a word boundary; MUL and SUM form
// the LBA. busy_o falls as done_o rises; the next request is taken that cycle.
// Configuration goes through cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i,
// always ready; the user must write it only while the block is idle, as the
// block does not enforce it. Reset sets the registers to their defaults and
// ends the current chain; the table contents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_cluster_run_walker_core
  import fcrw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [13:0] table_word_index_i,
  input  wire logic [31:0] table_word_data_i,
  input  wire logic [31:0] first_cluster_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output logic             done_o,
  output logic [31:0]      run_lba_o,
  output logic [4:0]       run_sectors_o,
  output logic             last_run_o,
  output logic             status_o
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  fcrw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fcrw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  fcrw_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .table_word_index_i (table_word_index_i),
    .table_word_data_i  (table_word_data_i),
    .first_cluster_i    (first_cluster_i),
    .done_o             (done_o),
    .run_lba_o          (run_lba_o),
    .run_sectors_o      (run_sectors_o),
    .last_run_o         (last_run_o),
    .status_o           (status_o)
  );

endmodule

`default_nettype wire

// ===== verif/fat_cluster_run_walker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_run_walker_checker
// Watches the request, configuration and result ports of the run walker. It
// keeps its own FAT table copy, chain position and register set, works out
// each run from the requests it sees, and compares every result against the
// oldest run still due.
// ----------------------------------------------------------------------------
module fat_cluster_run_walker_checker
  import fcrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [13:0] table_word_index_i,
  input  logic [31:0] table_word_data_i,
  input  logic [31:0] first_cluster_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        done_i,
  input  logic [31:0] run_lba_i,
  input  logic [4:0]  run_sectors_i,
  input  logic        last_run_i,
  input  logic        status_i,
  output int          mismatch_count_o,
  output int          runs_outstanding_o
);

  typedef struct {
    logic [31:0] lba;
    logic [4:0]  sectors;
    logic        last_run;
    logic        ended;
  } run_t;

  logic [31:0] fat_words [TableWords];
  logic [31:0] chain_cluster;
  cfg_t        regs;
  run_t        runs_due [$];
  int          mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] run walker mismatch: %s", $time, what);
  endtask

  function automatic logic [7:0] fat_byte(input logic [ByteAw-1:0] addr);
    return fat_words[addr[ByteAw-1:2]][8*addr[1:0] +: 8];
  endfunction

  function automatic logic [15:0] fat_half(input logic [ByteAw-1:0] addr);
    return {fat_byte(ByteAw'(addr + 1)), fat_byte(addr)};
  endfunction

  // Follows one FAT entry; byte addresses wrap around the table.
  function automatic logic [31:0] next_link(input logic [31:0] c);
    logic [ByteAw-1:0] a;
    logic [31:0]       v;
    logic [31:0]       limit;
    if (regs.fs_type == FsFat12) begin
      a = ByteAw'(c + (c >> 1));
      v = {16'h0, fat_half(a)};
      if (c[0]) v = v >> 4;
      v = v & 32'h0000_0FFF;
      limit = Fat12Limit;
    end else if (regs.fs_type == FsFat16) begin
      a = ByteAw'(c << 1);
      v = {16'h0, fat_half(a)};
      limit = Fat16Limit;
    end else begin
      a = ByteAw'(c << 2);
      v = {fat_half(ByteAw'(a + 2)), fat_half(a)};
      limit = Fat32Limit;
    end
    return (v >= limit) ? ChainEnd : v;
  endfunction

  task automatic walk_next_run();
    run_t        nr;
    logic [31:0] spc;
    logic [31:0] cur;
    logic [31:0] cnt;
    logic [31:0] nxt;
    logic [31:0] base;
    if (chain_cluster == ChainEnd) begin
      nr.lba = '0;
      nr.sectors = '0;
      nr.last_run = 1'b0;
      nr.ended = 1'b1;
    end else begin
      spc = 32'(regs.sectors_per_cluster);
      if (spc == 0) spc = 1;
      if (spc > MaxSectors) spc = MaxSectors;
      cur = chain_cluster;
      cnt = 1;
      nxt = next_link(cur);
      while (nxt != ChainEnd && nxt == cur + cnt && (cnt + 1) * spc <= MaxSectors) begin
        cnt++;
        nxt = next_link(nxt);
      end
      base = regs.fat_copies * regs.sectors_per_fat + regs.reserved_sectors;
      if (regs.fs_type == FsFat12 || regs.fs_type == FsFat16) begin
        base += 32'(regs.root_entry_count >> 4);
      end
      nr.lba = base + (cur - 2) * spc;
      nr.sectors = 5'(cnt * spc);
      nr.last_run = (nxt == ChainEnd);
      nr.ended = 1'b0;
      chain_cluster = nxt;
    end
    runs_due.push_back(nr);
  endtask

  task automatic check_run();
    run_t due;
    if (runs_due.size() == 0) begin
      flag_mismatch($sformatf("unrequested result lba=%h sectors=%0d", run_lba_i,
                              run_sectors_i));
      return;
    end
    due = runs_due.pop_front();
    if (run_lba_i !== due.lba)
      flag_mismatch($sformatf("run_lba %h, expected %h", run_lba_i, due.lba));
    if (run_sectors_i !== due.sectors)
      flag_mismatch($sformatf("run_sectors %0d, expected %0d", run_sectors_i, due.sectors));
    if (last_run_i !== due.last_run)
      flag_mismatch($sformatf("last_run %b, expected %b", last_run_i, due.last_run));
    if (status_i !== due.ended)
      flag_mismatch($sformatf("status %b, expected %b", status_i, due.ended));
  endtask

  // A result and a new request can meet at one edge; the result belongs to
  // the earlier request, so it is checked first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{fs_type: FsFat12, sectors_per_cluster: 5'd1, fat_copies: 3'd2,
               sectors_per_fat: 24'd9, reserved_sectors: 16'd1, root_entry_count: 16'd224};
      chain_cluster = ChainEnd;
      runs_due.delete();
      runs_outstanding_o <= 0;
    end else begin
      if (done_i) check_run();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgFsType:      regs.fs_type = cfg_data_i[1:0];
          CfgSecPerClus:  regs.sectors_per_cluster = cfg_data_i[4:0];
          CfgFatCopies:   regs.fat_copies = cfg_data_i[2:0];
          CfgSecPerFat:   regs.sectors_per_fat = cfg_data_i;
          CfgReserved:    regs.reserved_sectors = cfg_data_i[15:0];
          CfgRootEntries: regs.root_entry_count = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        case (opcode_i)
          OpWrite: fat_words[table_word_index_i] = table_word_data_i;
          OpStart: chain_cluster = first_cluster_i;
          OpNext:  walk_next_run();
          default: ;
        endcase
      end
      runs_outstanding_o <= runs_due.size();
    end
  end

endmodule

// ===== verif/fat_cluster_run_walker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_run_walker_core_tb
// Loads the whole FAT table, then builds cluster chains in FAT12, FAT16 and
// FAT32 form and walks them under a range of disk layouts, mixed with stray
// writes, starts and run requests. The checker beside the block judges every
// result; this module drives requests with random gaps and gives the verdict.
// ----------------------------------------------------------------------------
module fat_cluster_run_walker_core_tb;
  import fcrw_pkg::*;

  localparam int         RandomItems = 1400;
  localparam int         CycleLimit  = 1_000_000;
  localparam int         IdlePct     = 24;
  localparam logic [1:0] OpSpare     = 2'd3;
  localparam logic [1:0] FsFat32     = 2'd2;
  localparam logic [1:0] FsAlias32   = 2'd3;
  localparam logic [2:0] CfgSpareLo  = 3'd6;
  localparam logic [2:0] CfgSpareHi  = 3'd7;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        start_i            = 1'b0;
  logic [1:0]  opcode_i           = OpWrite;
  logic [13:0] table_word_index_i = '0;
  logic [31:0] table_word_data_i  = '0;
  logic [31:0] first_cluster_i    = '0;
  logic        cfg_valid_i        = 1'b0;
  logic [2:0]  cfg_index_i        = CfgFsType;
  logic [23:0] cfg_data_i         = '0;
  logic        busy_o;
  logic        cfg_ready_o;
  logic        done_o;
  logic [31:0] run_lba_o;
  logic [4:0]  run_sectors_o;
  logic        last_run_o;
  logic        status_o;

  int          mismatch_count;
  int          runs_outstanding;
  int          cycles   = 0;
  int          accepted = 0;
  bit          idle_on  = 1'b1;
  logic [1:0]  cur_fs   = FsFat12;
  logic [31:0] image [TableWords];

  always #5 clk_i = ~clk_i;

  fat_cluster_run_walker_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .opcode_i           (opcode_i),
    .table_word_index_i (table_word_index_i),
    .table_word_data_i  (table_word_data_i),
    .first_cluster_i    (first_cluster_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .run_lba_o          (run_lba_o),
    .run_sectors_o      (run_sectors_o),
    .last_run_o         (last_run_o),
    .status_o           (status_o)
  );

  fat_cluster_run_walker_checker u_run_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .opcode_i           (opcode_i),
    .table_word_index_i (table_word_index_i),
    .table_word_data_i  (table_word_data_i),
    .first_cluster_i    (first_cluster_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .done_i             (done_o),
    .run_lba_i          (run_lba_o),
    .run_sectors_i      (run_sectors_o),
    .last_run_i         (last_run_o),
    .status_i           (status_o),
    .mismatch_count_o   (mismatch_count),
    .runs_outstanding_o (runs_outstanding)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Leaves start_i high after acceptance so that a following request can go
  // out in the same cycle.
  task automatic send(input logic [1:0] op, input logic [13:0] idx, input logic [31:0] data,
                      input logic [31:0] clus);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    table_word_index_i <= idx;
    table_word_data_i <= data;
    first_cluster_i <= clus;
    do @(posedge clk_i); while (busy_o);
    if (op == OpWrite) image[idx] = data;
    if (op != OpSpare) accepted++;
  endtask

  task automatic start_chain(input logic [31:0] head);
    send(OpStart, 14'($urandom()), $urandom(), head);
  endtask

  task automatic next_run();
    send(OpNext, 14'($urandom()), $urandom(), $urandom());
  endtask

  function automatic logic [7:0] image_byte(input logic [ByteAw-1:0] a);
    return image[a[ByteAw-1:2]][8*a[1:0] +: 8];
  endfunction

  // Sets the FAT entry of cluster c to v in the current format and sends the
  // one or two table words that it touches.
  task automatic link(input logic [31:0] c, input logic [31:0] v);
    logic [ByteAw-1:0] a;
    logic [ByteAw-1:0] z;
    logic [15:0]       h;
    logic [31:0]       val;
    int                n;
    int                i;
    case (cur_fs)
      FsFat12: begin
        a = ByteAw'(c + (c >> 1));
        h = {image_byte(ByteAw'(a + 1)), image_byte(a)};
        h = c[0] ? {v[11:0], h[3:0]} : {h[15:12], v[11:0]};
        val = {16'h0, h};
        n = 2;
      end
      FsFat16: begin
        a = ByteAw'(c << 1);
        val = v;
        n = 2;
      end
      default: begin
        a = ByteAw'(c << 2);
        val = v;
        n = 4;
      end
    endcase
    for (i = 0; i < n; i++) begin
      z = ByteAw'(a + i);
      image[z[ByteAw-1:2]][8*z[1:0] +: 8] = val[8*i +: 8];
    end
    z = ByteAw'(a + n - 1);
    send(OpWrite, a[ByteAw-1:2], image[a[ByteAw-1:2]], $urandom());
    if (z[ByteAw-1:2] != a[ByteAw-1:2])
      send(OpWrite, z[ByteAw-1:2], image[z[ByteAw-1:2]], $urandom());
  endtask

  function automatic logic [31:0] random_cluster();
    case (cur_fs)
      FsFat12: return $urandom_range(2, 32'h0000_0FF6);
      FsFat16: return $urandom_range(2, 32'h0000_FFF6);
      default: return $urandom_range(2, 32'h0FFF_FFF6);
    endcase
  endfunction

  function automatic logic [31:0] end_marker();
    case (cur_fs)
      FsFat12: return $urandom_range(Fat12Limit, 32'h0000_0FFF);
      FsFat16: return $urandom_range(Fat16Limit, 32'h0000_FFFF);
      default: begin
        if ($urandom_range(0, 3) == 0) return $urandom_range(Fat32Limit, ChainEnd);
        return $urandom_range(Fat32Limit, 32'h0FFF_FFFF);
      end
    endcase
  endfunction

  // Builds a chain of len clusters from head, where each link goes to the
  // next cluster with probability link_pct, then asks for runs.
  task automatic run_chain(input logic [31:0] head, input int len, input int runs,
                           input int link_pct);
    logic [31:0] c;
    logic [31:0] nx;
    int          i;
    c = head;
    for (i = 1; i < len; i++) begin
      nx = ($urandom_range(0, 99) < link_pct) ? c + 1 : random_cluster();
      link(c, nx);
      c = nx;
    end
    link(c, end_marker());
    start_chain(head);
    repeat (runs) next_run();
  endtask

  // Waits until every run has come back and the block has gone idle.
  task automatic quiesce();
    start_i <= 1'b0;
    do @(posedge clk_i); while (runs_outstanding != 0 || busy_o);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgFsType) cur_fs = val[1:0];
  endtask

  // Sometimes sets the data bits above a register's width.
  function automatic logic [23:0] padded(input int w, input logic [23:0] val);
    logic [23:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 24'($urandom() << w) : '0;
    return junk | val;
  endfunction

  task automatic configure(input logic [1:0] fs, input logic [4:0] spc, input logic [2:0] copies,
                           input logic [23:0] spf, input logic [15:0] rsv,
                           input logic [15:0] root);
    quiesce();
    set_reg(CfgFsType, padded(2, fs));
    set_reg(CfgSecPerClus, padded(5, spc));
    set_reg(CfgFatCopies, padded(3, copies));
    set_reg(CfgSecPerFat, spf);
    set_reg(CfgReserved, padded(16, rsv));
    set_reg(CfgRootEntries, padded(16, root));
    if ($urandom_range(0, 3) == 0)
      set_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, 24'($urandom()));
  endtask

  initial begin
    int          i;
    int          base;
    int          since_cfg;
    int          len;
    logic [4:0]  spc;
    logic [23:0] spf;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the chain has ended, so this run request reads no table.
    next_run();
    send(OpSpare, 14'($urandom()), $urandom(), $urandom());

    // Every word is written before any walk can reach it.
    for (i = 0; i < TableWords; i++) send(OpWrite, 14'(i), $urandom(), $urandom());

    run_chain(32'd2, 3, 2, 100);
    // This FAT12 entry sits on the last byte of the table and wraps to byte 0.
    run_chain(32'h0000_AAAA, 2, 2, 100);
    start_chain(ChainEnd);
    next_run();
    start_chain(32'd0);
    next_run();
    start_chain(32'd1);
    next_run();

    configure(FsFat16, 5'd0, 3'd7, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
    run_chain(32'h0000_7FF0, 20, 3, 100);

    configure(FsAlias32, 5'd17, 3'd0, 24'd0, 16'd0, 16'h1234);
    // The next cluster after 0xFFFFFFFE would be the end marker itself.
    run_chain(32'hFFFF_FFFE, 1, 2, 0);
    run_chain(32'h0000_0100, 3, 4, 100);

    configure(FsFat32, 5'd16, 3'd1, 24'd1, 16'd32, 16'd0);
    run_chain(32'h0FFF_FFF0, 3, 3, 100);

    configure(FsFat12, 5'd8, 3'd4, 24'd3, 16'd4, 16'd512);
    run_chain(32'd10, 5, 4, 100);

    base = accepted;
    since_cfg = accepted;
    while (accepted - base < RandomItems) begin
      idle_on = (accepted - base < 500) || (accepted - base >= 750);
      if (accepted - since_cfg >= 150) begin
        case ($urandom_range(0, 3))
          0:       spc = 5'd0;
          1:       spc = 5'($urandom_range(MaxSectors + 1, 31));
          default: spc = 5'($urandom_range(1, MaxSectors));
        endcase
        spf = $urandom_range(0, 1) ? 24'($urandom()) : 24'($urandom_range(1, 256));
        configure(2'($urandom()), spc, 3'($urandom()), spf, 16'($urandom()),
                  16'($urandom()));
        since_cfg = accepted;
      end
      if ($urandom_range(0, 99) < 80) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        run_chain(($urandom_range(0, 15) == 0) ? $urandom() : random_cluster(), len,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len + 1,
                  $urandom_range(0, 1) ? 90 : $urandom_range(0, 100));
      end else begin
        case ($urandom_range(0, 3))
          0:       send(OpWrite, 14'($urandom()), $urandom(), $urandom());
          1:       start_chain(($urandom_range(0, 3) == 0) ? $urandom() : random_cluster());
          2:       next_run();
          default: send(OpSpare, 14'($urandom()), $urandom(), $urandom());
        endcase
      end
    end

    quiesce();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
